// ===== sv/lie_pkg.sv =====
// shared types and constants for the list intersection engine
// no dependencies; imported by every module of the block except lie_ram
package lie_pkg;

	localparam int SET_CAPACITY = 4096;
	localparam int ADDR_W       = $clog2(SET_CAPACITY);
	localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
	localparam int DATA_W       = 32;

	localparam logic [2:0] KIND_LOAD  = 3'd0;
	localparam logic [2:0] KIND_PROBE = 3'd1;
	localparam logic [2:0] KIND_END   = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [11:0] index;
	} lie_in_t;

	typedef struct packed {
		logic        found;
		logic [12:0] set_count;
		logic [31:0] read_value;
		logic        overflow;
	} lie_out_t;

	// memory requests from the sequencer, in current/next bank terms
	typedef struct packed {
		logic              wr_cur;
		logic [ADDR_W-1:0] wr_cur_addr;
		logic              wr_nxt;
		logic [ADDR_W-1:0] wr_nxt_addr;
		logic [DATA_W-1:0] wr_data;
		logic [ADDR_W-1:0] rd_addr;
		logic              sel;
	} lie_mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} lie_state_t;

endpackage

// ===== sv/lie_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/lie_ctrl.sv =====
// sequencer: command decode, counts, bank select, linear scan, result register
// depends on lie_pkg
module lie_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  lie_pkg::lie_in_t     cmd,
	input  logic [31:0]          rdata,
	output lie_pkg::lie_mem_req_t mem,
	output logic                 done,
	output lie_pkg::lie_out_t    rsp
);
	import lie_pkg::*;

	lie_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cur_cnt_q, cur_cnt_d;
	logic [CNT_W-1:0]  nxt_cnt_q, nxt_cnt_d;
	logic [CNT_W-1:0]  ptr_q, ptr_d;
	logic              sel_q, sel_d;
	logic              rd_vld_s1, rd_vld_d;
	logic [31:0]       value_q, value_d;
	logic              done_q, done_d;
	lie_out_t          rsp_q, rsp_d;
	logic              issue;
	logic              hit;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign issue = (ptr_q < cur_cnt_q);
	assign hit   = rd_vld_s1 && (rdata == value_q);

	always_comb begin
		state_d   = state_q;
		cur_cnt_d = cur_cnt_q;
		nxt_cnt_d = nxt_cnt_q;
		ptr_d     = ptr_q;
		sel_d     = sel_q;
		rd_vld_d  = 1'b0;
		value_d   = value_q;
		done_d    = 1'b0;
		rsp_d     = '0;

		mem             = '0;
		mem.sel         = sel_q;
		mem.wr_cur_addr = cur_cnt_q[ADDR_W-1:0];
		mem.wr_nxt_addr = nxt_cnt_q[ADDR_W-1:0];
		mem.wr_data     = (state_q == ST_IDLE) ? cmd.value : value_q;
		mem.rd_addr     = ptr_q[ADDR_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.kind)
						KIND_LOAD: begin
							done_d = 1'b1;
							if (cur_cnt_q < CNT_W'(SET_CAPACITY)) begin
								mem.wr_cur = 1'b1;
								cur_cnt_d  = cur_cnt_q + 1'b1;
							end else begin
								rsp_d.overflow = 1'b1;
							end
						end
						KIND_PROBE: begin
							if (cur_cnt_q == '0) begin
								done_d = 1'b1;
							end else begin
								state_d = ST_SCAN;
								value_d = cmd.value;
								ptr_d   = '0;
							end
						end
						KIND_END: begin
							// bank swap replaces the copy
							done_d    = 1'b1;
							sel_d     = ~sel_q;
							cur_cnt_d = nxt_cnt_q;
							nxt_cnt_d = '0;
						end
						KIND_CLEAR: begin
							done_d    = 1'b1;
							cur_cnt_d = '0;
							nxt_cnt_d = '0;
						end
						KIND_READ: begin
							if (32'(cmd.index) < 32'(cur_cnt_q)) begin
								mem.rd_addr = ADDR_W'(cmd.index);
								state_d     = ST_READ;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				priority if (hit) begin
					state_d     = ST_IDLE;
					done_d      = 1'b1;
					rsp_d.found = 1'b1;
					if (nxt_cnt_q < CNT_W'(SET_CAPACITY)) begin
						mem.wr_nxt = 1'b1;
						nxt_cnt_d  = nxt_cnt_q + 1'b1;
					end else begin
						rsp_d.overflow = 1'b1;
					end
				end else if (!issue && !rd_vld_s1) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end else if (issue) begin
					rd_vld_d = 1'b1;
					ptr_d    = ptr_q + 1'b1;
				end else begin
					rd_vld_d = 1'b0;
				end
			end
			ST_READ: begin
				state_d          = ST_IDLE;
				done_d           = 1'b1;
				rsp_d.read_value = rdata;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		rsp_d.set_count = 13'(cur_cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_cnt_q <= '0;
			nxt_cnt_q <= '0;
			ptr_q     <= '0;
			sel_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_cnt_q <= cur_cnt_d;
			nxt_cnt_q <= nxt_cnt_d;
			ptr_q     <= ptr_d;
			sel_q     <= sel_d;
			rd_vld_s1 <= rd_vld_d;
			done_q    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
		rsp_q   <= rsp_d;
	end

endmodule

// ===== sv/list_intersection_engine.sv =====
// top level of the posting list intersection engine
// depends on lie_pkg, lie_ram, lie_ctrl
//
// one command transaction is taken when start is high and busy is low, and
// each transaction produces exactly one result, shown on rsp for a single
// cycle with done high; the receiver cannot stall, so it must take every
// result in the cycle it appears. load, end list, clear, unused kinds and an
// out of range read answer in the cycle after start; a read of an entry in
// range passes through the read state, and a probe's duration is set by the
// linear scan that reads the current bank one entry per cycle through the
// ram's single read port. a probe that hits stops the scan early.
module list_intersection_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lie_pkg::lie_in_t  cmd,
	output logic              done,
	output lie_pkg::lie_out_t rsp
);
	import lie_pkg::*;

	lie_mem_req_t      mem;
	logic              we_a, we_b;
	logic [ADDR_W-1:0] waddr_a, waddr_b;
	logic [DATA_W-1:0] rdata_a, rdata_b;
	logic [DATA_W-1:0] rdata_cur;

	// sequencer: decodes the command, owns both counts and the bank select
	lie_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.rdata  (rdata_cur),
		.mem    (mem),
		.done   (done),
		.rsp    (rsp)
	);

	// sel low: bank a holds the current set, bank b collects the next set
	// ending a list flips sel, so no copy pass is needed
	assign we_a    = mem.sel ? mem.wr_nxt : mem.wr_cur;
	assign we_b    = mem.sel ? mem.wr_cur : mem.wr_nxt;
	assign waddr_a = mem.sel ? mem.wr_nxt_addr : mem.wr_cur_addr;
	assign waddr_b = mem.sel ? mem.wr_cur_addr : mem.wr_nxt_addr;

	// reads only target entries below the count, written in earlier cycles,
	// and a load never overlaps a scan or read, so no forwarding is needed
	assign rdata_cur = mem.sel ? rdata_b : rdata_a;

	lie_ram #(
		.WIDTH (DATA_W),
		.DEPTH (SET_CAPACITY)
	) u_bank_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (mem.wr_data),
		.raddr (mem.rd_addr),
		.rdata (rdata_a)
	);

	lie_ram #(
		.WIDTH (DATA_W),
		.DEPTH (SET_CAPACITY)
	) u_bank_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_b),
		.wdata (mem.wr_data),
		.raddr (mem.rd_addr),
		.rdata (rdata_b)
	);

endmodule

// ===== sv/lie_chk.sv =====
// port level checker for the list intersection engine, bound to the top
// depends on lie_pkg and list_intersection_engine
module lie_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input lie_pkg::lie_in_t  cmd,
	input logic              done,
	input lie_pkg::lie_out_t rsp
);
	import lie_pkg::*;

	// commands other than probe and read answer in the next cycle and leave the block free
	a_short_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind != KIND_PROBE && cmd.kind != KIND_READ
		|=> done && !busy)
		else $error("single cycle transaction gave no result");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == KIND_CLEAR |=> rsp.set_count == '0)
		else $error("clear left a nonzero count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(rsp.set_count) <= 32'(SET_CAPACITY))
		else $error("count beyond capacity");

	a_read_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.read_value != '0 |-> !rsp.found && !rsp.overflow)
		else $error("read data with probe or drop flags");

	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == KIND_END
		|=> !rsp.found && !rsp.overflow && rsp.read_value == '0)
		else $error("end of list reported flags");

endmodule

bind list_intersection_engine lie_chk u_lie_chk (.*);
